// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while reset is low.
`define BEAS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define BEAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/beas_pkg.sv =====
// Package for the block exponent aligned sum: controller states,
// command/status structs and shared constants. No dependencies.
`default_nettype none

package beas_pkg;

  localparam int unsigned BEAS_MAX_ELEMENTS = 128;

  localparam int unsigned MANT_W = 64;
  localparam int unsigned EXP_W  = 8;
  localparam int unsigned SUM_W  = 32;
  localparam int unsigned CNT_W  = 32;

  localparam int unsigned IN_DATA_W  = 72;   // mantissa, exponent
  localparam int unsigned OUT_DATA_W = 104;  // sum, exponent, sat total, underflow total

  localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SUM,
    ST_DRAIN
  } beas_state_e;

  // controller -> datapath
  typedef struct packed {
    logic wr;        // input beat accepted
    logic last;      // accepted beat closes the vector
    logic rd;        // issue one buffer read for the sum pass
    logic out_load;  // capture result into output register
  } beas_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rd_last;     // current read is the final element
    logic pipe_empty;  // no element in flight in the sum pipe
    logic out_free;    // output register can take a result this cycle
  } beas_status_t;

endpackage

`default_nettype wire

// ===== src/beas_ctrl.sv =====
// Controller for the block exponent aligned sum: load, sum pass, drain.
// Depends on beas_pkg.
`default_nettype none

module beas_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_tvalid_i,
  input  wire                   s_tlast_i,
  output logic                  s_tready_o,
  input  beas_pkg::beas_status_t status_i,
  output beas_pkg::beas_cmd_t    cmd_o
);
  import beas_pkg::*;

  beas_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    s_tready_o   = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        s_tready_o = 1'b1;
        cmd_o.wr   = s_tvalid_i;
        cmd_o.last = s_tvalid_i & s_tlast_i;
        if (s_tvalid_i && s_tlast_i) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.rd = 1'b1;
        if (status_i.rd_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty && status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/beas_dp.sv =====
// Datapath for the block exponent aligned sum: element buffer, max tracking,
// align/round pipe, saturating accumulator, counters, output register. Uses beas_pkg.
`default_nettype none

module beas_dp #(
  parameter int unsigned MAX_ELEMENTS = beas_pkg::BEAS_MAX_ELEMENTS
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  beas_pkg::beas_cmd_t                 cmd_i,
  output beas_pkg::beas_status_t              status_o,
  input  wire  [beas_pkg::IN_DATA_W-1:0]      in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [beas_pkg::OUT_DATA_W-1:0]     out_data_o
);
  import beas_pkg::*;

  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned WORD_W = MANT_W + EXP_W;

  // input fields
  logic [MANT_W-1:0]       in_mant;
  logic signed [EXP_W-1:0] in_exp;
  assign in_mant = in_data_i[MANT_W-1:0];
  assign in_exp  = in_data_i[MANT_W +: EXP_W];

  // ---------------- load side ----------------
  logic [CW-1:0] cnt_q, n_q, ptr_q;
  logic          wr_act;
  logic          found_q;
  logic signed [EXP_W-1:0] dom_q;
  logic          dom_upd;

  assign wr_act  = cmd_i.wr & (cnt_q < CW'(MAX_ELEMENTS));
  assign dom_upd = wr_act & (|in_mant) & (!found_q || (in_exp > dom_q));

  logic [WORD_W-1:0] mem_q [MAX_ELEMENTS];
  logic [WORD_W-1:0] rd_word_q;

  always_ff @(posedge clk_i) begin
    if (wr_act) begin
      mem_q[cnt_q[AW-1:0]] <= {in_exp, in_mant};
    end
    if (cmd_i.rd) begin
      rd_word_q <= mem_q[ptr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      n_q     <= '0;
      ptr_q   <= '0;
      found_q <= 1'b0;
      dom_q   <= '0;
    end else begin
      if (cmd_i.last) begin
        n_q   <= wr_act ? cnt_q + CW'(1) : cnt_q;
        cnt_q <= '0;
        ptr_q <= '0;
      end else if (wr_act) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.rd) begin
        ptr_q <= ptr_q + CW'(1);
      end
      if (dom_upd) begin
        dom_q   <= in_exp;
        found_q <= 1'b1;
      end else if (cmd_i.out_load) begin
        found_q <= 1'b0;
      end
    end
  end

  assign status_o.rd_last = (ptr_q + CW'(1)) == n_q;

  // ---------------- sum pipe ----------------
  // s0: buffer word   s1: magnitude/gap   s2: shift + round decision
  // s3: rounded magnitude   then accumulate
  logic v0_q, v1_q, v2_q, v3_q;

  logic [MANT_W-1:0]       rd_mant;
  logic signed [EXP_W-1:0] rd_exp;
  assign rd_mant = rd_word_q[MANT_W-1:0];
  assign rd_exp  = rd_word_q[MANT_W +: EXP_W];

  logic [MANT_W-1:0] mag1_q;
  logic              neg1_q;
  logic [EXP_W:0]    gap1_q;
  logic [EXP_W:0]    gap_s1;

  assign gap_s1 = {dom_q[EXP_W-1], dom_q} - {rd_exp[EXP_W-1], rd_exp};

  // s2 combinational: shift by gap and round half to even
  logic [5:0]        gap_sh;
  logic              gap_big, gap_nz;
  logic [MANT_W-1:0] q_s2, rem_s2, mask_s2, half_s2;
  logic              rup_s2;

  assign gap_sh  = gap1_q[5:0];
  assign gap_big = |gap1_q[EXP_W:6];
  assign gap_nz  = |gap1_q;
  assign q_s2    = mag1_q >> gap_sh;
  assign mask_s2 = (MANT_W'(1) << gap_sh) - MANT_W'(1);
  assign rem_s2  = mag1_q & mask_s2;
  assign half_s2 = MANT_W'(1) << (gap_sh - 6'd1);
  assign rup_s2  = gap_nz & !gap_big &
                   ((rem_s2 > half_s2) || ((rem_s2 == half_s2) && q_s2[0]));

  logic [MANT_W-1:0] q2_q;
  logic              rup2_q, neg2_q, gnz2_q;
  logic [MANT_W-1:0] mag3_q;
  logic              neg3_q, gnz3_q;

  always_ff @(posedge clk_i) begin
    mag1_q <= rd_mant[MANT_W-1] ? (~rd_mant + MANT_W'(1)) : rd_mant;
    neg1_q <= rd_mant[MANT_W-1];
    gap1_q <= gap_s1;
    q2_q   <= gap_big ? '0 : q_s2;
    rup2_q <= rup_s2;
    neg2_q <= neg1_q;
    gnz2_q <= gap_nz;
    mag3_q <= q2_q + MANT_W'(rup2_q);
    neg3_q <= neg2_q;
    gnz3_q <= gnz2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.rd;
      v1_q <= v0_q & (|rd_mant);  // zero mantissas drop out here
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign status_o.pipe_empty = !(v0_q | v1_q | v2_q | v3_q);

  // ---------------- accumulate ----------------
  logic signed [SUM_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]        sat_cnt_q, uf_cnt_q;
  logic [SUM_W+2:0]        acc_ext, mag_ext, sum_s;
  logic                    big, ovf, sat, uf;

  assign acc_ext = {{3{acc_q[SUM_W-1]}}, acc_q};
  assign mag_ext = {2'b00, mag3_q[SUM_W:0]};
  assign sum_s   = neg3_q ? (acc_ext - mag_ext) : (acc_ext + mag_ext);
  assign big     = |mag3_q[MANT_W-1:SUM_W+1];
  assign ovf     = !((sum_s[SUM_W+2:SUM_W-1] == 4'b0000) ||
                     (sum_s[SUM_W+2:SUM_W-1] == 4'b1111));
  assign sat     = v3_q & (big | ovf);
  assign uf      = v3_q & gnz3_q & (mag3_q == '0);

  always_comb begin
    acc_d = acc_q;
    if (sat) begin
      acc_d = neg3_q ? SUM_MIN : SUM_MAX;
    end else if (v3_q) begin
      acc_d = sum_s[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      sat_cnt_q <= '0;
      uf_cnt_q  <= '0;
    end else begin
      if (cmd_i.last) begin
        acc_q <= '0;
      end else begin
        acc_q <= acc_d;
      end
      if (sat) begin
        sat_cnt_q <= sat_cnt_q + CNT_W'(1);
      end
      if (uf) begin
        uf_cnt_q <= uf_cnt_q + CNT_W'(1);
      end
    end
  end

  // ---------------- output register ----------------
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign status_o.out_free = !out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {uf_cnt_q, sat_cnt_q, (found_q ? dom_q : EXP_W'(0)), acc_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== src/block_exponent_aligned_sum.sv =====
// Top level of the block exponent aligned sum: controller plus datapath.
// Depends on beas_pkg, beas_ctrl and beas_dp.
//
// Usage:
//  - Slave stream carries one vector element per beat: tdata holds the
//    signed 64-bit mantissa and the signed 8-bit exponent, tlast marks the
//    final element. Only the first MAX_ELEMENTS elements are kept; a later
//    beat with tlast still closes the vector.
//  - Loading takes one cycle per element. The largest exponent among the
//    nonzero elements is tracked while loading, so no separate max pass.
//  - After the last beat the block stops accepting and runs the sum pass:
//    one buffer read per element (one element per cycle through the single
//    read port), then the align/round/accumulate pipe drains, and the result
//    register is loaded once the pipe is empty and the output register is
//    free. tready stays low throughout the pass and the drain.
//  - The master stream emits one beat per vector: the saturated int32 sum,
//    the dominant exponent (0 when every mantissa is zero) and the running
//    saturation and underflow counts, which wrap at 2^32.
//  - The result sits in an output register; the block goes back to loading
//    the next vector while it waits. A new result waits at the end of its
//    pass until the previous one is taken, so a stalled receiver holds off
//    the next vector only once its pass is done.
//  - Reset clears the element count, counters and stream valid. The buffer
//    has no reset and needs no clearing pass: only entries written in the
//    current vector are read.
`default_nettype none

module block_exponent_aligned_sum #(
  parameter int unsigned MAX_ELEMENTS = beas_pkg::BEAS_MAX_ELEMENTS
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // slave side, tdata: [63:0] mantissa, [71:64] exponent
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire  [beas_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  wire                                s_axis_tlast_i,   // last
  // master side, tdata: [31:0] sum_mantissa, [39:32] block_exponent,
  // [71:40] saturation_total, [103:72] underflow_total
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  output logic [beas_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import beas_pkg::*;

  beas_cmd_t    cmd;
  beas_status_t status;

  beas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tlast_i  (s_axis_tlast_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  beas_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ===== src/beas_checker.sv =====
// Port-level checker for block_exponent_aligned_sum, bound to the top level.
// Depends on beas_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module beas_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             s_axis_tvalid_i,
  input wire                             s_axis_tready_o,
  input wire                             s_axis_tlast_i,
  input wire                             m_axis_tvalid_o,
  input wire                             m_axis_tready_i,
  input wire [beas_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);

  // stalled result beat holds
  `BEAS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result beat changed while stalled")

  // closing beat starts the sum pass: input side closes
  `BEAS_ASSERT_NEXT(a_last_stops, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, !s_axis_tready_o, "input open right after last beat")

  // input is still closed part way through the pass plus pipe drain
  `BEAS_ASSERT(a_pass_len, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |-> ##3 !s_axis_tready_o, "sum pass shorter than pipe depth")

  // a new result only appears at the end of a pass
  `BEAS_ASSERT(a_result_after_pass, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o), "result appeared while loading")

endmodule

bind block_exponent_aligned_sum beas_checker u_beas_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
